>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion helpers of the ranging block, used by dstwr_back
// Clocked concurrent assertions, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, suspended while in reset.
`define DSTWR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a property on every rising edge of clk, reset included.
`define DSTWR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg - shared constants of the ranging block
// Status codes, register map, reset values, divider limits and the queue status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dstwr_pkg;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic       REG_DISTANCE_SCALE = 1'b0;
    localparam logic [31:0] SCALE_RESET = 32'd20150973;

    localparam int QUO_BITS = 32;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // fifo fill state seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/ds_twr_time_of_flight.sv
// Throughput: one exchange per cycle unless the output or a full queue holds the flow;
// the 32-stage restoring divider takes one bit a stage.
// A four-word queue lets the product front end keep running while the output stalls.
// Reset (rst_n low, asynchronous) empties all stages and sets distance_scale to 20150973.
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight - double-sided two-way ranging time of flight
// Exact asymmetric time of flight with saturation and a Q16 distance output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ds_twr_time_of_flight #(
    parameter int STAMP_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        poll_tx_time,
    input  wire logic [31:0]        resp_rx_time,
    input  wire logic [31:0]        final_tx_time,
    input  wire logic [31:0]        poll_rx_time,
    input  wire logic [31:0]        resp_depart_time,
    input  wire logic [31:0]        final_rx_time,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      flight_ticks,
    output logic signed [47:0]      distance_q16,
    output logic [1:0]              status
);
    localparam int W  = STAMP_BITS;
    localparam int FW = 5*W + 3;

    // distance_scale register: written at the access phase of an APB write
    logic [31:0] scale_reg;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == dstwr_pkg::REG_DISTANCE_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= dstwr_pkg::SCALE_RESET;
        else if (wr_en)
            scale_reg <= pwdata;
    end

    // only paddr[2] decodes: addresses 0 to 3 all read the register, 4 to 7 read zero
    assign prdata = (paddr[2] == dstwr_pkg::REG_DISTANCE_SCALE) ? scale_reg : 32'd0;

    dstwr_pkg::fifo_status_t fifo_st;
    logic          push, pop;
    logic [FW-1:0] push_word, pop_word;

    // front: intervals, divisor, products; holds whenever the queue is full
    dstwr_front #(.W(W)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .valid            (in_valid),
        .stall            (in_stall),
        .poll_tx_time     (poll_tx_time),
        .resp_rx_time     (resp_rx_time),
        .final_tx_time    (final_tx_time),
        .poll_rx_time     (poll_rx_time),
        .resp_depart_time (resp_depart_time),
        .final_rx_time    (final_rx_time),
        .fifo_st          (fifo_st),
        .push             (push),
        .push_word        (push_word)
    );

    dstwr_fifo #(.DW(FW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .st        (fifo_st)
    );

    // back: divide, saturate, scale; advances unless the result is stalled
    dstwr_back #(.W(W)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_st      (fifo_st),
        .pop_word     (pop_word),
        .pop          (pop),
        .scale        (scale_reg),
        .valid        (out_valid),
        .stall        (out_stall),
        .flight_ticks (flight_ticks),
        .distance_q16 (distance_q16),
        .status       (status)
    );
endmodule
`default_nettype wire

>>> hw/rtl/dstwr_front.sv
// ----------------------------------------------------------------------------
// dstwr_front - interval and product front end
// Forms the four wrapped intervals, the divisor and both products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dstwr_front #(
    parameter int W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  valid,
    output logic                       stall,
    input  wire logic [31:0]           poll_tx_time,
    input  wire logic [31:0]           resp_rx_time,
    input  wire logic [31:0]           final_tx_time,
    input  wire logic [31:0]           poll_rx_time,
    input  wire logic [31:0]           resp_depart_time,
    input  wire logic [31:0]           final_rx_time,
    input  wire dstwr_pkg::fifo_status_t fifo_st,
    output logic                       push,
    output logic [5*W+2:0]             push_word
);
    localparam int D  = W + 2;
    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int XW = W + 32;

    logic fe;
    assign fe    = !fifo_st.full;
    assign stall = !fe;

    // stage 1: intervals
    logic         v1_reg;
    logic [W-1:0] ra_reg, rb_reg, da_reg, db_reg;
    logic [W-1:0] ra_next, rb_next, da_next, db_next;
    logic [XW-1:0] ptx, rrx, ftx, prx, rtx, frx;

    always_comb
    begin
        ptx = {{W{1'b0}}, poll_tx_time};
        rrx = {{W{1'b0}}, resp_rx_time};
        ftx = {{W{1'b0}}, final_tx_time};
        prx = {{W{1'b0}}, poll_rx_time};
        rtx = {{W{1'b0}}, resp_depart_time};
        frx = {{W{1'b0}}, final_rx_time};
        ra_next = rrx[W-1:0] - ptx[W-1:0];
        da_next = ftx[W-1:0] - rrx[W-1:0];
        rb_next = frx[W-1:0] - rtx[W-1:0];
        db_next = rtx[W-1:0] - prx[W-1:0];
    end

    // stage 2: divisor and half products
    logic         v2_reg;
    logic [D-1:0] d2_reg;
    logic [2*H-1:0] pll_reg, qll_reg, plh_reg, qlh_reg, phl_reg, qhl_reg;
    logic [2*L-1:0] phh_reg, qhh_reg;

    // stage 3: full products
    logic           v3_reg;
    logic           z3_reg;
    logic [D-1:0]   d3_reg;
    logic [2*W-1:0] p3_reg, q3_reg;
    logic [2*W-1:0] p_next, q_next;

    always_comb
    begin
        p_next = {{(2*W-2*H){1'b0}}, pll_reg}
               + ({{(2*W-2*H){1'b0}}, plh_reg} << H)
               + ({{(2*W-2*H){1'b0}}, phl_reg} << H)
               + ({{(2*W-2*L){1'b0}}, phh_reg} << (2*H));
        q_next = {{(2*W-2*H){1'b0}}, qll_reg}
               + ({{(2*W-2*H){1'b0}}, qlh_reg} << H)
               + ({{(2*W-2*H){1'b0}}, qhl_reg} << H)
               + ({{(2*W-2*L){1'b0}}, qhh_reg} << (2*H));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            da_reg <= da_next;
            db_reg <= db_next;
            d2_reg <= {2'b00, ra_reg} + {2'b00, rb_reg} + {2'b00, da_reg} + {2'b00, db_reg};
            pll_reg <= {{L{1'b0}}, ra_reg[H-1:0]} * {{L{1'b0}}, rb_reg[H-1:0]};
            plh_reg <= {{L{1'b0}}, ra_reg[H-1:0]} * {{(2*H-L){1'b0}}, rb_reg[W-1:H]};
            phl_reg <= {{(2*H-L){1'b0}}, ra_reg[W-1:H]} * {{L{1'b0}}, rb_reg[H-1:0]};
            phh_reg <= {{L{1'b0}}, ra_reg[W-1:H]} * {{L{1'b0}}, rb_reg[W-1:H]};
            qll_reg <= {{L{1'b0}}, da_reg[H-1:0]} * {{L{1'b0}}, db_reg[H-1:0]};
            qlh_reg <= {{L{1'b0}}, da_reg[H-1:0]} * {{(2*H-L){1'b0}}, db_reg[W-1:H]};
            qhl_reg <= {{(2*H-L){1'b0}}, da_reg[W-1:H]} * {{L{1'b0}}, db_reg[H-1:0]};
            qhh_reg <= {{L{1'b0}}, da_reg[W-1:H]} * {{L{1'b0}}, db_reg[W-1:H]};
            d3_reg <= d2_reg;
            z3_reg <= (d2_reg == '0);
            p3_reg <= p_next;
            q3_reg <= q_next;
        end
    end

    assign push      = v3_reg && fe;
    assign push_word = {z3_reg, d3_reg, p3_reg, q3_reg};
endmodule
`default_nettype wire

>>> hw/rtl/dstwr_fifo.sv
// ----------------------------------------------------------------------------
// dstwr_fifo - four-word queue between front and back
// Decouples the product front end from the divider back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dstwr_fifo #(
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_word,
    input  wire logic          pop,
    output logic [DW-1:0]      pop_word,
    output dstwr_pkg::fifo_status_t st
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign pop_word = mem[rd_reg];
    assign st.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign st.empty = (cnt_reg == '0);
endmodule
`default_nettype wire

>>> hw/rtl/dstwr_back.sv
// ----------------------------------------------------------------------------
// dstwr_back - divider and scaling back end
// Pipelined restoring division, saturation and distance scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dstwr_back #(
    parameter int W = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dstwr_pkg::fifo_status_t fifo_st,
    input  wire logic [5*W+2:0]    pop_word,
    output logic                   pop,
    input  wire logic [31:0]       scale,
    output logic                   valid,
    input  wire logic              stall,
    output logic signed [31:0]     flight_ticks,
    output logic signed [47:0]     distance_q16,
    output logic [1:0]             status
);
    localparam int D  = W + 2;
    localparam int NQ = dstwr_pkg::QUO_BITS;
    localparam int CW = 2*W + 34;

    logic be;
    assign be  = !(valid && stall);
    assign pop = be && !fifo_st.empty;

    // stage B0: word from the queue
    logic           b0v_reg, b0z_reg;
    logic [D-1:0]   b0d_reg;
    logic [2*W-1:0] b0p_reg, b0q_reg;

    // stage B1: magnitude and sign
    logic           b1v_reg, b1z_reg, b1n_reg;
    logic [D-1:0]   b1d_reg;
    logic [2*W-1:0] b1m_reg;

    // divider chain, index 0 is the entry
    logic           dv_reg  [0:NQ];
    logic           dz_reg  [0:NQ];
    logic           dn_reg  [0:NQ];
    logic           do_reg  [0:NQ];
    logic [D-1:0]   dd_reg  [0:NQ];
    logic [D-1:0]   drem_reg[0:NQ];
    logic [NQ-1:0]  dlow_reg[0:NQ];
    logic [NQ-1:0]  dq_reg  [0:NQ];

    logic [CW-1:0] mag_x, rem_x;
    always_comb
    begin
        mag_x = {{(CW-2*W){1'b0}}, b1m_reg};
        rem_x = mag_x >> NQ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0v_reg   <= 1'b0;
            b1v_reg   <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (be)
        begin
            b0v_reg   <= !fifo_st.empty;
            b1v_reg   <= b0v_reg;
            dv_reg[0] <= b1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            {b0z_reg, b0d_reg, b0p_reg, b0q_reg} <= pop_word;
            b1z_reg <= b0z_reg;
            b1d_reg <= b0d_reg;
            b1n_reg <= (b0p_reg < b0q_reg);
            b1m_reg <= (b0p_reg < b0q_reg) ? (b0q_reg - b0p_reg) : (b0p_reg - b0q_reg);
            // quotient of 2^32 or more saturates either way
            dz_reg[0]   <= b1z_reg;
            dn_reg[0]   <= b1n_reg;
            dd_reg[0]   <= b1d_reg;
            do_reg[0]   <= (mag_x >= ({{(CW-D){1'b0}}, b1d_reg} << NQ));
            drem_reg[0] <= rem_x[D-1:0];
            dlow_reg[0] <= b1m_reg[NQ-1:0];
            dq_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        logic [D:0] trial;
        logic       take;
        always_comb
        begin
            trial = {drem_reg[k], dlow_reg[k][NQ-1]};
            take  = (trial >= {1'b0, dd_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (be)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                dz_reg[k+1]   <= dz_reg[k];
                dn_reg[k+1]   <= dn_reg[k];
                do_reg[k+1]   <= do_reg[k];
                dd_reg[k+1]   <= dd_reg[k];
                drem_reg[k+1] <= take ? D'(trial - {1'b0, dd_reg[k]}) : trial[D-1:0];
                dlow_reg[k+1] <= {dlow_reg[k][NQ-2:0], 1'b0};
                dq_reg[k+1]   <= {dq_reg[k][NQ-2:0], take};
            end
        end
    end

    // saturate and scale
    logic        sv_reg, sz_reg, sn_reg, ss_reg;
    logic [31:0] st_reg;
    logic [63:0] sp_reg;
    logic [31:0] lim, tmag;
    logic        sat;

    always_comb
    begin
        lim  = dn_reg[NQ] ? dstwr_pkg::NEG_LIMIT : dstwr_pkg::POS_LIMIT;
        sat  = do_reg[NQ] || (dq_reg[NQ] > lim);
        tmag = sat ? lim : dq_reg[NQ];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
            valid  <= 1'b0;
        end
        else if (be)
        begin
            sv_reg <= dv_reg[NQ];
            valid  <= sv_reg;
        end
    end

    logic [63:0] rnd;
    logic [47:0] dist_next;
    always_comb
    begin
        rnd = sp_reg + 64'h0000_0000_0000_FFFF;
        dist_next = sn_reg ? (48'd0 - rnd[63:16]) : sp_reg[63:16];
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            sz_reg <= dz_reg[NQ];
            sn_reg <= dn_reg[NQ];
            ss_reg <= sat;
            st_reg <= tmag;
            sp_reg <= {32'd0, tmag} * {32'd0, scale};
            if (sz_reg)
            begin
                flight_ticks <= '0;
                distance_q16 <= '0;
                status       <= dstwr_pkg::STATUS_ZERO;
            end
            else
            begin
                flight_ticks <= sn_reg ? (32'd0 - st_reg) : st_reg;
                distance_q16 <= dist_next;
                status       <= ss_reg ? dstwr_pkg::STATUS_SAT : dstwr_pkg::STATUS_OK;
            end
        end
    end

    `DSTWR_ASSERT(a_zero_out, clk, rst_n, valid && status == dstwr_pkg::STATUS_ZERO |-> flight_ticks == 0 && distance_q16 == 0)
    `DSTWR_ASSERT(a_sat_out, clk, rst_n, valid && status == dstwr_pkg::STATUS_SAT |-> flight_ticks == 32'sh7FFF_FFFF || flight_ticks == -32'sh8000_0000)
    `DSTWR_ASSERT(a_sign_out, clk, rst_n, valid && status == dstwr_pkg::STATUS_OK && flight_ticks >= 0 |-> distance_q16 >= 0)
endmodule
`default_nettype wire
